[src/zzr_pkg.sv]
// ----------------------------------------------------------------------------
// zzr_pkg: shared types and constants for the zigzag block reorder
// Sizes, register indexes and the structs passed between the front end,
// the index realigner, the command queue and the bank side.
// ----------------------------------------------------------------------------
package zzr_pkg;

   localparam int MAX_SIZE     = 16;
   localparam int SAMPLE_WIDTH = 16;

   // block row/col position, side length (1..MAX_SIZE), linear index, n*n
   localparam int POS_W = $clog2(MAX_SIZE);
   localparam int N_W   = $clog2(MAX_SIZE + 1);
   localparam int IDX_W = $clog2(MAX_SIZE * MAX_SIZE);
   localparam int TOT_W = $clog2(MAX_SIZE * MAX_SIZE + 1);

   // bank address is {bank, row, col}
   localparam int ADDR_W    = 1 + 2 * POS_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // configuration port
   localparam int BS_W     = 5;
   localparam int CSR_DW   = BS_W;
   localparam int CSR_AW   = 1;
   localparam int BS_RESET = 8;

   localparam logic [CSR_AW-1:0] REG_BLOCK_SIZE = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] REG_DIRECTION  = CSR_AW'(1);

   localparam logic DIR_FORWARD = 1'b0;
   localparam logic DIR_INVERSE = 1'b1;

   // one bank operation: write the incoming sample, optionally read one out
   typedef struct packed {
      logic [ADDR_W-1:0]              wr_addr;
      logic signed [SAMPLE_WIDTH-1:0] wr_data;
      logic                           rd_en;
      logic [ADDR_W-1:0]              rd_addr;
      logic                           block_end;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [N_W-1:0]   n;
      logic [IDX_W-1:0] fill_idx;
      logic [IDX_W-1:0] drain_idx;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [IDX_W-1:0] fill_q;
      logic [N_W-1:0]   fill_r;
      logic [IDX_W-1:0] drain_q;
      logic [N_W-1:0]   drain_r;
   } div_res_type;

endpackage

[src/zzr_if.sv]
// ----------------------------------------------------------------------------
// zzr_if: valid/ready channels of the zigzag block reorder
// Input sample channel and result channel.
// ----------------------------------------------------------------------------
interface zzr_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [zzr_pkg::SAMPLE_WIDTH-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface zzr_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [zzr_pkg::SAMPLE_WIDTH-1:0]  sample_out;
   logic                                     block_end;

   modport source (output valid, output sample_out, output block_end, input ready);
   modport sink   (input valid, input sample_out, input block_end, output ready);
endinterface

[src/zigzag_block_reorder.sv]
// ----------------------------------------------------------------------------
// zigzag_block_reorder: raster <-> zigzag reorder of square sample blocks
// Top level: intake, command queue and double-banked sample store.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the queue has room and no resize runs,
// and gives one reordered sample per clock once the first block has filled,
// while samples keep coming and the output does not stall; results of a
// block come out while the next block fills the other bank. A result passes
// the queue and then the registered bank read after the sample that
// releases it, and waits while the output stalls. Writing block_size stalls
// the input while a one-bit-per-cycle divider realigns the row and column
// counters; writing direction costs nothing. No clearing pass after reset.
// Out-of-range sizes clamp: 0 acts as 1, above MAX_SIZE as MAX_SIZE.
module zigzag_block_reorder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [zzr_pkg::CSR_AW-1:0]   csr_index,
   input  logic [zzr_pkg::CSR_DW-1:0]   csr_wdata,
   zzr_req_if.sink                      req_ch,
   zzr_rsp_if.source                    rsp_ch
);
   import zzr_pkg::*;

   logic    push;
   logic    pop;
   logic    fifo_full;
   logic    fifo_empty;
   cmd_type cmd;
   cmd_type head;

   zzr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .fifo_full (fifo_full),
      .push      (push),
      .cmd       (cmd)
   );

   zzr_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (cmd),
      .full  (fifo_full),
      .pop   (pop),
      .head  (head),
      .empty (fifo_empty)
   );

   zzr_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (fifo_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("command queue written while full");

   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      (pop && head.rd_en) |=> rsp_ch.valid)
      else $error("bank read did not produce a result");

   a_resize_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == REG_BLOCK_SIZE) |=> !req_ch.ready)
      else $error("input open while counters realign");
`endif

endmodule

[src/zzr_rediv.sv]
// ----------------------------------------------------------------------------
// zzr_rediv: index realigner
// Restoring divider, one quotient bit per cycle, that splits the fill and
// drain indexes into row and column for a newly written block size.
// ----------------------------------------------------------------------------
module zzr_rediv (
   input  logic                 clock,
   input  logic                 reset,
   input  zzr_pkg::div_req_type dreq,
   output zzr_pkg::div_res_type dres
);
   import zzr_pkg::*;

   localparam int CNT_W = $clog2(IDX_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [N_W-1:0]   n_ff;
   logic [IDX_W-1:0] fsh_ff, dsh_ff;
   logic [IDX_W-1:0] fq_ff, dq_ff;
   logic [N_W-1:0]   fr_ff, dr_ff;
   logic [N_W:0]     fstep, dstep;

   // returns {quotient bit, new remainder}
   function automatic logic [N_W:0] div_bit(logic [N_W-1:0] r, logic b, logic [N_W-1:0] n);
      logic [N_W:0] t;
      t = {r, b};
      if (t >= {1'b0, n}) begin
         return {1'b1, N_W'(t - {1'b0, n})};
      end
      return {1'b0, t[N_W-1:0]};
   endfunction

   assign fstep = div_bit(fr_ff, fsh_ff[IDX_W-1], n_ff);
   assign dstep = div_bit(dr_ff, dsh_ff[IDX_W-1], n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (dreq.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(IDX_W);
            n_ff    <= dreq.n;
            fsh_ff  <= dreq.fill_idx;
            dsh_ff  <= dreq.drain_idx;
            fq_ff   <= '0;
            dq_ff   <= '0;
            fr_ff   <= '0;
            dr_ff   <= '0;
         end else if (busy_ff) begin
            fr_ff  <= fstep[N_W-1:0];
            dr_ff  <= dstep[N_W-1:0];
            fq_ff  <= {fq_ff[IDX_W-2:0], fstep[N_W]};
            dq_ff  <= {dq_ff[IDX_W-2:0], dstep[N_W]};
            fsh_ff <= fsh_ff << 1;
            dsh_ff <= dsh_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign dres.busy    = busy_ff;
   assign dres.done    = done_ff;
   assign dres.fill_q  = fq_ff;
   assign dres.fill_r  = fr_ff;
   assign dres.drain_q = dq_ff;
   assign dres.drain_r = dr_ff;

endmodule

[src/zzr_front.sv]
// ----------------------------------------------------------------------------
// zzr_front: intake and address generation
// Holds configuration, fill/drain counters and the zigzag walker; turns each
// accepted sample into one bank command for the queue.
// ----------------------------------------------------------------------------
module zzr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [zzr_pkg::CSR_AW-1:0]   csr_index,
   input  logic [zzr_pkg::CSR_DW-1:0]   csr_wdata,
   zzr_req_if.sink                      req_ch,
   input  logic                         fifo_full,
   output logic                         push,
   output zzr_pkg::cmd_type             cmd
);
   import zzr_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } pos_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             up;
   } walk_type;

   localparam walk_type WALK_HOME = '0;
   localparam pos_type  POS_HOME  = '0;

   function automatic logic [N_W-1:0] side_of(logic [BS_W-1:0] bs);
      if (bs == '0) begin
         return N_W'(1);
      end else if (32'(bs) > MAX_SIZE) begin
         return N_W'(MAX_SIZE);
      end
      return N_W'(bs);
   endfunction

   function automatic pos_type rast_next(pos_type p, logic [N_W-1:0] n);
      logic [N_W-1:0] c1;
      pos_type        o;
      c1 = N_W'(p.col) + 1'b1;
      o  = p;
      if (c1 >= n) begin
         o.col = '0;
         o.row = p.row + 1'b1;
      end else begin
         o.col = POS_W'(c1);
      end
      return o;
   endfunction

   function automatic walk_type walk_step(walk_type w, logic [N_W-1:0] n);
      logic [N_W-1:0] r, c, nm1;
      walk_type       o;
      r   = N_W'(w.row);
      c   = N_W'(w.col);
      nm1 = n - 1'b1;
      o   = w;
      if (n > N_W'(1)) begin
         if (r == '0 && c == '0) begin
            c    = N_W'(1);
            o.up = 1'b0;
         end else if (w.up) begin
            if (c == nm1) begin
               r    = r + 1'b1;
               o.up = 1'b0;
            end else if (r == '0) begin
               c    = c + 1'b1;
               o.up = 1'b0;
            end else begin
               r = r - 1'b1;
               c = c + 1'b1;
            end
         end else begin
            if (r == nm1) begin
               c    = c + 1'b1;
               o.up = 1'b1;
            end else if (c == '0) begin
               r    = r + 1'b1;
               o.up = 1'b1;
            end else begin
               r = r + 1'b1;
               c = c - 1'b1;
            end
         end
         if (r >= n || c >= n) begin
            r    = '0;
            c    = '0;
            o.up = 1'b0;
         end
      end
      o.row = POS_W'(r);
      o.col = POS_W'(c);
      return o;
   endfunction

   logic [N_W-1:0]   n_ff;
   logic [TOT_W-1:0] total_ff;
   logic             dir_ff;
   logic [IDX_W-1:0] fi_ff, fi_in, fi_now;
   logic [IDX_W-1:0] di_ff, di_in, di_now;
   pos_type          fpos_ff, fpos_in, fpos_now;
   pos_type          dpos_ff, dpos_in, dpos_now;
   walk_type         walk_ff, walk_in, walk_now, walk_mid;
   logic             fb_ff, fb_in;
   logic             dv_ff, dv_in;
   logic             last_fill, last_drain;
   logic [N_W-1:0]   n_wr;
   logic             accept;
   div_req_type      dreq;
   div_res_type      dres;

   assign n_wr = side_of(csr_wdata[BS_W-1:0]);

   assign dreq.start     = csr_we && csr_index == REG_BLOCK_SIZE;
   assign dreq.n         = n_wr;
   assign dreq.fill_idx  = fi_ff;
   assign dreq.drain_idx = di_ff;

   zzr_rediv u_rediv (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .dres  (dres)
   );

   assign req_ch.ready = !dres.busy && !dres.done && !fifo_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept;

   always_comb begin
      fi_now   = fi_ff;
      fpos_now = fpos_ff;
      di_now   = di_ff;
      dpos_now = dpos_ff;
      walk_now = walk_ff;
      // counters left out of range by a size change restart first
      if (TOT_W'(fi_ff) >= total_ff) begin
         fi_now   = '0;
         fpos_now = POS_HOME;
         if (dir_ff == DIR_INVERSE) begin
            walk_now = WALK_HOME;
         end
      end
      if (TOT_W'(di_ff) >= total_ff) begin
         di_now   = '0;
         dpos_now = POS_HOME;
         if (dir_ff == DIR_FORWARD) begin
            walk_now = WALK_HOME;
         end
      end
      if (N_W'(walk_now.row) >= n_ff || N_W'(walk_now.col) >= n_ff) begin
         walk_now = WALK_HOME;
      end

      last_drain = TOT_W'(di_now) == total_ff - 1'b1;
      last_fill  = TOT_W'(fi_now) == total_ff - 1'b1;

      cmd.rd_en     = dv_ff;
      cmd.block_end = last_drain;
      cmd.rd_addr   = (dir_ff == DIR_INVERSE) ? {~fb_ff, dpos_now.row, dpos_now.col}
                                              : {~fb_ff, walk_now.row, walk_now.col};

      walk_mid = walk_now;
      dv_in    = dv_ff;
      di_in    = di_now;
      dpos_in  = dpos_now;
      if (dv_ff) begin
         if (dir_ff == DIR_FORWARD) begin
            walk_mid = walk_step(walk_now, n_ff);
         end
         if (last_drain) begin
            dv_in   = 1'b0;
            di_in   = '0;
            dpos_in = POS_HOME;
         end else begin
            di_in   = di_now + 1'b1;
            dpos_in = rast_next(dpos_now, n_ff);
         end
      end

      cmd.wr_data = req_ch.sample;
      cmd.wr_addr = (dir_ff == DIR_INVERSE) ? {fb_ff, walk_mid.row, walk_mid.col}
                                            : {fb_ff, fpos_now.row, fpos_now.col};

      walk_in = walk_mid;
      if (dir_ff == DIR_INVERSE) begin
         walk_in = walk_step(walk_mid, n_ff);
      end

      fb_in = fb_ff;
      if (last_fill) begin
         // bank complete: swap and start draining it
         fi_in   = '0;
         fpos_in = POS_HOME;
         fb_in   = ~fb_ff;
         dv_in   = 1'b1;
         di_in   = '0;
         dpos_in = POS_HOME;
         walk_in = WALK_HOME;
      end else begin
         fi_in   = fi_now + 1'b1;
         fpos_in = rast_next(fpos_now, n_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= side_of(BS_W'(BS_RESET));
         total_ff <= TOT_W'(side_of(BS_W'(BS_RESET))) * TOT_W'(side_of(BS_W'(BS_RESET)));
         dir_ff   <= DIR_FORWARD;
         fi_ff    <= '0;
         di_ff    <= '0;
         fpos_ff  <= POS_HOME;
         dpos_ff  <= POS_HOME;
         walk_ff  <= WALK_HOME;
         fb_ff    <= 1'b0;
         dv_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_BLOCK_SIZE: begin
                  n_ff     <= n_wr;
                  total_ff <= TOT_W'(n_wr) * TOT_W'(n_wr);
               end
               REG_DIRECTION: begin
                  dir_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            fi_ff   <= fi_in;
            di_ff   <= di_in;
            fpos_ff <= fpos_in;
            dpos_ff <= dpos_in;
            walk_ff <= walk_in;
            fb_ff   <= fb_in;
            dv_ff   <= dv_in;
         end else if (dres.done) begin
            fpos_ff.row <= POS_W'(dres.fill_q);
            fpos_ff.col <= POS_W'(dres.fill_r);
            dpos_ff.row <= POS_W'(dres.drain_q);
            dpos_ff.col <= POS_W'(dres.drain_r);
         end
      end
   end

endmodule

[src/zzr_fifo.sv]
// ----------------------------------------------------------------------------
// zzr_fifo: command queue
// Short first-in first-out buffer of bank commands between intake and banks.
// ----------------------------------------------------------------------------
module zzr_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  zzr_pkg::cmd_type din,
   output logic             full,
   input  logic             pop,
   output zzr_pkg::cmd_type head,
   output logic             empty
);
   import zzr_pkg::*;

   cmd_type          slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wp_ff, rp_ff;
   logic [PTR_W:0]   cnt_ff;

   assign full  = cnt_ff == (PTR_W + 1)'(FIFO_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

[src/zzr_back.sv]
// ----------------------------------------------------------------------------
// zzr_back: sample banks and result stage
// Executes queued commands: writes the filling bank, reads the full bank
// into the registered result that drives the output channel.
// ----------------------------------------------------------------------------
module zzr_back (
   input  logic             clock,
   input  logic             reset,
   input  zzr_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   zzr_rsp_if.source        rsp_ch
);
   import zzr_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] bank_mem [MEM_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] q_ff;
   logic                           end_ff;
   logic                           vld_ff;
   logic                           out_free;

   assign out_free = !vld_ff || rsp_ch.ready;
   // a write-only command never waits on the output side
   assign pop      = !empty && (!head.rd_en || out_free);

   always_ff @(posedge clock) begin
      if (pop) begin
         bank_mem[head.wr_addr] <= head.wr_data;
      end
      if (pop && head.rd_en) begin
         q_ff   <= bank_mem[head.rd_addr];
         end_ff <= head.block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (pop && head.rd_en) begin
         vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         vld_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid      = vld_ff;
   assign rsp_ch.sample_out = q_ff;
   assign rsp_ch.block_end  = end_ff;

endmodule
